/* rtl/krt_pkg.sv */
package krt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = 7;
    localparam int WORD_W = 32;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_DUMP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_DUP     = 3'd2,
        ST_MISSING = 3'd3,
        ST_EMPTY   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [WORD_W-1:0] second_value;
        logic [WORD_W-1:0] first_value;
        logic [WORD_W-1:0] key;
    } entry_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        entry_t            wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        status_t           status;
        logic [WORD_W-1:0] out_key;
        logic [WORD_W-1:0] out_first;
        logic [WORD_W-1:0] out_second;
        logic [CNT_W-1:0]  record_count;
        logic              last;
    } result_t;

endpackage

/* rtl/krt_mem.sv */
module krt_mem (
    input  logic              clk,
    input  krt_pkg::mem_req_t req,
    output krt_pkg::entry_t   rdata
);

    krt_pkg::entry_t mem [krt_pkg::TABLE_DEPTH];
    krt_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/krt_ctrl.sv */
module krt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  krt_pkg::cmd_t     in_cmd,
    input  krt_pkg::entry_t   in_entry,
    output logic              res_valid,
    input  logic              res_ready,
    output krt_pkg::result_t  res,
    output krt_pkg::mem_req_t mem_req,
    input  krt_pkg::entry_t   mem_rdata
);

    krt_pkg::state_t state_reg, state_next;
    krt_pkg::cmd_t cmd_reg, cmd_next;
    krt_pkg::entry_t entry_reg, entry_next;
    krt_pkg::result_t res_reg, res_next;
    logic [krt_pkg::CNT_W-1:0] count_reg, count_next;
    logic [krt_pkg::CNT_W-1:0] ptr_reg, ptr_next;
    logic cmp_valid_reg, cmp_valid_next;
    logic [krt_pkg::ADDR_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic pend_reg, pend_next;
    logic [krt_pkg::ADDR_W-1:0] pend_addr_reg, pend_addr_next;

    logic match;
    logic more;
    logic full;
    logic dump_last;
    logic [krt_pkg::CNT_W-1:0] ptr_inc;

    assign match = cmp_valid_reg && (mem_rdata.key == entry_reg.key);
    assign more = ptr_reg < count_reg;
    assign full = count_reg >= krt_pkg::CNT_W'(krt_pkg::TABLE_DEPTH);
    assign ptr_inc = ptr_reg + krt_pkg::CNT_W'(1);
    assign dump_last = ptr_inc == count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= krt_pkg::S_IDLE;
            count_reg <= '0;
            cmp_valid_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        entry_reg <= entry_next;
        res_reg <= res_next;
        ptr_reg <= ptr_next;
        cmp_idx_reg <= cmp_idx_next;
        pend_addr_reg <= pend_addr_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            krt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if ((in_cmd == krt_pkg::CMD_INSERT && full)
                        || (in_cmd == krt_pkg::CMD_DUMP && count_reg == '0))
                    begin
                        state_next = krt_pkg::S_RESP;
                    end
                    else if (in_cmd == krt_pkg::CMD_DUMP)
                    begin
                        state_next = krt_pkg::S_DUMP_RD;
                    end
                    else
                    begin
                        state_next = krt_pkg::S_SEARCH;
                    end
                end
            end
            krt_pkg::S_SEARCH:
            begin
                if (match)
                begin
                    state_next = (cmd_reg == krt_pkg::CMD_DELETE) ? krt_pkg::S_SHIFT
                                                                  : krt_pkg::S_RESP;
                end
                else if (!more)
                begin
                    state_next = krt_pkg::S_RESP;
                end
            end
            krt_pkg::S_SHIFT:
            begin
                if (!more)
                begin
                    state_next = krt_pkg::S_RESP;
                end
            end
            krt_pkg::S_DUMP_RD:
            begin
                state_next = krt_pkg::S_DUMP_OUT;
            end
            krt_pkg::S_DUMP_OUT:
            begin
                if (res_ready)
                begin
                    state_next = dump_last ? krt_pkg::S_IDLE : krt_pkg::S_DUMP_RD;
                end
            end
            krt_pkg::S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = krt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = krt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_next = cmd_reg;
        entry_next = entry_reg;
        res_next = res_reg;
        count_next = count_reg;
        ptr_next = ptr_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next = cmp_idx_reg;
        pend_next = pend_reg;
        pend_addr_next = pend_addr_reg;
        in_ready = 1'b0;
        res_valid = 1'b0;
        res = res_reg;
        mem_req.we = 1'b0;
        mem_req.waddr = cmp_idx_reg;
        mem_req.wdata = entry_reg;
        mem_req.raddr = ptr_reg[krt_pkg::ADDR_W-1:0];

        case (state_reg)
            krt_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next = in_cmd;
                    entry_next = in_entry;
                    ptr_next = '0;
                    cmp_valid_next = 1'b0;
                    pend_next = 1'b0;
                    res_next = '0;
                    res_next.record_count = count_reg;
                    res_next.last = 1'b1;
                    if (in_cmd == krt_pkg::CMD_INSERT && full)
                    begin
                        res_next.status = krt_pkg::ST_FULL;
                    end
                    else if (in_cmd == krt_pkg::CMD_DUMP && count_reg == '0)
                    begin
                        res_next.status = krt_pkg::ST_EMPTY;
                    end
                end
            end
            krt_pkg::S_SEARCH:
            begin
                res_next = '0;
                res_next.record_count = count_reg;
                res_next.last = 1'b1;
                if (match)
                begin
                    cmp_valid_next = 1'b0;
                    case (cmd_reg)
                        krt_pkg::CMD_INSERT:
                        begin
                            res_next.status = krt_pkg::ST_DUP;
                        end
                        krt_pkg::CMD_UPDATE:
                        begin
                            mem_req.we = 1'b1;
                            res_next.status = krt_pkg::ST_OK;
                            res_next.out_key = entry_reg.key;
                            res_next.out_first = mem_rdata.first_value;
                            res_next.out_second = mem_rdata.second_value;
                        end
                        default:
                        begin
                            ptr_next = krt_pkg::CNT_W'(cmp_idx_reg) + krt_pkg::CNT_W'(1);
                            pend_next = 1'b0;
                        end
                    endcase
                end
                else if (more)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next = ptr_reg[krt_pkg::ADDR_W-1:0];
                    ptr_next = ptr_inc;
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                    if (cmd_reg == krt_pkg::CMD_INSERT)
                    begin
                        mem_req.we = 1'b1;
                        mem_req.waddr = count_reg[krt_pkg::ADDR_W-1:0];
                        count_next = count_reg + krt_pkg::CNT_W'(1);
                        res_next.status = krt_pkg::ST_OK;
                        res_next.record_count = count_reg + krt_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        res_next.status = krt_pkg::ST_MISSING;
                    end
                end
            end
            krt_pkg::S_SHIFT:
            begin
                if (pend_reg)
                begin
                    mem_req.we = 1'b1;
                    mem_req.waddr = pend_addr_reg;
                    mem_req.wdata = mem_rdata;
                end
                if (more)
                begin
                    pend_next = 1'b1;
                    pend_addr_next = ptr_reg[krt_pkg::ADDR_W-1:0] - krt_pkg::ADDR_W'(1);
                    ptr_next = ptr_inc;
                end
                else
                begin
                    pend_next = 1'b0;
                    count_next = count_reg - krt_pkg::CNT_W'(1);
                    res_next = '0;
                    res_next.status = krt_pkg::ST_OK;
                    res_next.out_key = entry_reg.key;
                    res_next.record_count = count_reg - krt_pkg::CNT_W'(1);
                    res_next.last = 1'b1;
                end
            end
            krt_pkg::S_DUMP_RD:
            begin
            end
            krt_pkg::S_DUMP_OUT:
            begin
                res_valid = 1'b1;
                res.status = krt_pkg::ST_OK;
                res.out_key = mem_rdata.key;
                res.out_first = mem_rdata.first_value;
                res.out_second = mem_rdata.second_value;
                res.record_count = count_reg;
                res.last = dump_last;
                if (res_ready)
                begin
                    ptr_next = ptr_inc;
                end
            end
            krt_pkg::S_RESP:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* rtl/keyed_record_table.sv */
// Channel  Direction  Payload
// s_*      in         tuser: cmd; tdata: key, first_value, second_value
// m_*      out        tuser: status; tdata: out_key, out_first, out_second,
//                     record_count; tlast: last
//
// A command is taken only while the sequencer is idle. Insert, update and delete
// scan the table with one key compare per cycle; delete then moves the later
// records down at one per cycle through the table's write port. A dump reads
// each record, then holds it as a beat until taken before reading the next.
// Reset clears the sequencer, the output valid and the record count; the table
// contents need no clearing.
// A stalled output beat holds its register, and the sequencer waits on it.
module keyed_record_table (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // key, first_value, second_value
    input  logic [1:0]   s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // out_key, out_first, out_second, record_count, zero pad
    output logic [2:0]   m_tuser,   // status
    output logic         m_tlast
);

    krt_pkg::mem_req_t mem_req;
    krt_pkg::entry_t mem_rdata;
    krt_pkg::entry_t in_entry;
    krt_pkg::result_t res;
    krt_pkg::result_t out_reg;
    logic res_valid;
    logic res_ready;
    logic m_tvalid_reg;

    assign in_entry.key = s_tdata[31:0];
    assign in_entry.first_value = s_tdata[63:32];
    assign in_entry.second_value = s_tdata[95:64];

    krt_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    krt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (krt_pkg::cmd_t'(s_tuser)),
        .in_entry  (in_entry),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = {1'b0, out_reg.record_count, out_reg.out_second,
                      out_reg.out_first, out_reg.out_key};
    assign m_tuser = out_reg.status;
    assign m_tlast = out_reg.last;

endmodule

/* sim/tb_keyed_record_table.sv */
module tb_keyed_record_table;

    typedef struct {
        krt_pkg::cmd_t cmd;
        logic [31:0]   key;
        logic [31:0]   first;
        logic [31:0]   second;
    } table_cmd_t;

    typedef struct {
        krt_pkg::status_t status;
        logic [31:0]      key;
        logic [31:0]      first;
        logic [31:0]      second;
        logic [6:0]       count;
        logic             last;
    } table_beat_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    table_cmd_t  cmd_backlog[$];
    table_beat_t expected_beats[$];
    logic [31:0] gen_keys[$];

    logic [31:0] tbl_key[0:krt_pkg::TABLE_DEPTH-1];
    logic [31:0] tbl_first[0:krt_pkg::TABLE_DEPTH-1];
    logic [31:0] tbl_second[0:krt_pkg::TABLE_DEPTH-1];
    int          tbl_count = 0;
    int          peak_count = 0;

    table_cmd_t  cur_cmd;
    table_beat_t want;
    int          burst_left = 1;
    int          gap_left = 0;
    int          rx_cycle = 0;
    int          hold_left = 0;
    int          rx_mode = 0;
    int          mode_left = 0;
    int          errors = 0;
    int          beats_seen = 0;
    int          cmd_tally[4] = '{0, 0, 0, 0};
    int          status_tally[5] = '{0, 0, 0, 0, 0};

    keyed_record_table uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic push_beat(input table_beat_t b);
        expected_beats.push_back(b);
        status_tally[b.status]++;
    endtask

    task automatic apply_table_command(input table_cmd_t c);
        table_beat_t b;
        int          slot;
        int          i;
        b.status = krt_pkg::ST_OK;
        b.key = '0;
        b.first = '0;
        b.second = '0;
        b.last = 1'b1;
        slot = -1;
        cmd_tally[c.cmd]++;
        for (i = 0; i < tbl_count; i++)
        begin
            if (slot < 0 && tbl_key[i] == c.key)
                slot = i;
        end
        case (c.cmd)
            krt_pkg::CMD_INSERT:
            begin
                if (tbl_count >= krt_pkg::TABLE_DEPTH)
                    b.status = krt_pkg::ST_FULL;
                else if (slot >= 0)
                    b.status = krt_pkg::ST_DUP;
                else
                begin
                    tbl_key[tbl_count] = c.key;
                    tbl_first[tbl_count] = c.first;
                    tbl_second[tbl_count] = c.second;
                    tbl_count++;
                end
            end
            krt_pkg::CMD_UPDATE:
            begin
                if (slot < 0)
                    b.status = krt_pkg::ST_MISSING;
                else
                begin
                    b.key = c.key;
                    b.first = tbl_first[slot];
                    b.second = tbl_second[slot];
                    tbl_first[slot] = c.first;
                    tbl_second[slot] = c.second;
                end
            end
            krt_pkg::CMD_DELETE:
            begin
                if (slot < 0)
                    b.status = krt_pkg::ST_MISSING;
                else
                begin
                    for (i = slot; i < tbl_count - 1; i++)
                    begin
                        tbl_key[i] = tbl_key[i + 1];
                        tbl_first[i] = tbl_first[i + 1];
                        tbl_second[i] = tbl_second[i + 1];
                    end
                    tbl_count--;
                    b.key = c.key;
                end
            end
            default:
            begin
                if (tbl_count == 0)
                    b.status = krt_pkg::ST_EMPTY;
                else
                begin
                    for (i = 0; i < tbl_count; i++)
                    begin
                        b.key = tbl_key[i];
                        b.first = tbl_first[i];
                        b.second = tbl_second[i];
                        b.count = tbl_count[6:0];
                        b.last = (i == tbl_count - 1);
                        push_beat(b);
                    end
                    return;
                end
            end
        endcase
        if (tbl_count > peak_count)
            peak_count = tbl_count;
        b.count = tbl_count[6:0];
        push_beat(b);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 15))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] held_key();
        if (gen_keys.size() == 0)
            return $urandom;
        return gen_keys[$urandom_range(0, gen_keys.size() - 1)];
    endfunction

    function automatic logic [31:0] fresh_key();
        return ($urandom_range(0, 7) == 0) ? rand_word() : $urandom;
    endfunction

    task automatic queue_cmd(input krt_pkg::cmd_t c, input logic [31:0] k,
                             input logic [31:0] f, input logic [31:0] s);
        table_cmd_t t;
        int         hit;
        int         i;
        t.cmd = c;
        t.key = k;
        t.first = f;
        t.second = s;
        cmd_backlog.push_back(t);
        hit = -1;
        for (i = 0; i < gen_keys.size(); i++)
        begin
            if (gen_keys[i] == k)
                hit = i;
        end
        if (c == krt_pkg::CMD_INSERT && hit < 0 && gen_keys.size() < krt_pkg::TABLE_DEPTH)
            gen_keys.push_back(k);
        else if (c == krt_pkg::CMD_DELETE && hit >= 0)
            gen_keys.delete(hit);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                apply_table_command(cur_cmd);
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (cmd_backlog.size() > 0)
                begin
                    cur_cmd = cmd_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {cur_cmd.second, cur_cmd.first, cur_cmd.key};
                    s_tuser <= cur_cmd.cmd;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                                 : $urandom_range(1, 8);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            rx_cycle++;
            if (rx_cycle == 2500 || rx_cycle == 12000)
                hold_left = 400;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 80);
                end
                else
                    mode_left--;
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 9) < 7);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            beats_seen++;
            if (expected_beats.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected beat: status %0d key %h %h %h count %0d last %b",
                             m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
                             m_tdata[102:96], m_tlast);
            end
            else
            begin
                want = expected_beats.pop_front();
                if (m_tuser !== want.status || m_tdata[31:0] !== want.key
                    || m_tdata[63:32] !== want.first || m_tdata[95:64] !== want.second
                    || m_tdata[102:96] !== want.count || m_tlast !== want.last)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("Mismatch on beat %0d: expected status %0d key %h %h %h",
                                 beats_seen, want.status, want.key, want.first,
                                 want.second);
                        $display("    expected count %0d last %b", want.count, want.last);
                        $display("    got status %0d key %h %h %h count %0d last %b",
                                 m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
                                 m_tdata[102:96], m_tlast);
                    end
                end
            end
        end
    end

    initial
    begin
        int          r;
        int          settle;
        logic [31:0] k;

        queue_cmd(krt_pkg::CMD_DUMP, 32'h0, 32'h0, 32'h0);
        queue_cmd(krt_pkg::CMD_UPDATE, 32'd100, 32'h1, 32'h2);
        queue_cmd(krt_pkg::CMD_DELETE, 32'd100, 32'h0, 32'h0);
        queue_cmd(krt_pkg::CMD_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_cmd(krt_pkg::CMD_INSERT, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_cmd(krt_pkg::CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_cmd(krt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_cmd(krt_pkg::CMD_INSERT, 32'h7FFF_FFFF, 32'h1111_1111, 32'h2222_2222);
        queue_cmd(krt_pkg::CMD_UPDATE, 32'h0000_0000, 32'h5555_5555, 32'hAAAA_AAAA);
        queue_cmd(krt_pkg::CMD_UPDATE, 32'h1234_5678, 32'h3333_3333, 32'h4444_4444);
        queue_cmd(krt_pkg::CMD_DUMP, 32'h0, 32'h0, 32'h0);
        queue_cmd(krt_pkg::CMD_DELETE, 32'h8000_0000, 32'h0, 32'h0);
        queue_cmd(krt_pkg::CMD_DELETE, 32'hFFFF_FFFF, 32'h0, 32'h0);
        queue_cmd(krt_pkg::CMD_INSERT, 32'd100, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_cmd(krt_pkg::CMD_DELETE, 32'h0000_0000, 32'h0, 32'h0);
        queue_cmd(krt_pkg::CMD_DELETE, 32'h0000_0000, 32'h0, 32'h0);
        queue_cmd(krt_pkg::CMD_DUMP, 32'h0, 32'h0, 32'h0);
        queue_cmd(krt_pkg::CMD_UPDATE, 32'd100, 32'h8000_0000, 32'h0000_0000);
        queue_cmd(krt_pkg::CMD_DELETE, 32'h7FFF_FFFF, 32'h0, 32'h0);
        queue_cmd(krt_pkg::CMD_DELETE, 32'd100, 32'h0, 32'h0);
        queue_cmd(krt_pkg::CMD_DUMP, 32'h0, 32'h0, 32'h0);

        while (gen_keys.size() < krt_pkg::TABLE_DEPTH)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                queue_cmd(krt_pkg::CMD_INSERT, fresh_key(), rand_word(), rand_word());
            else if (r < 85)
                queue_cmd(krt_pkg::CMD_INSERT, held_key(), rand_word(), rand_word());
            else if (r < 93)
                queue_cmd(krt_pkg::CMD_UPDATE, held_key(), rand_word(), rand_word());
            else if (r < 96)
                queue_cmd(krt_pkg::CMD_DUMP, rand_word(), rand_word(), rand_word());
            else
                queue_cmd(krt_pkg::CMD_DELETE, held_key(), rand_word(), rand_word());
        end
        queue_cmd(krt_pkg::CMD_INSERT, fresh_key(), rand_word(), rand_word());
        queue_cmd(krt_pkg::CMD_INSERT, held_key(), rand_word(), rand_word());
        queue_cmd(krt_pkg::CMD_UPDATE, held_key(), rand_word(), rand_word());
        queue_cmd(krt_pkg::CMD_DUMP, rand_word(), rand_word(), rand_word());

        while (cmd_backlog.size() < 200)
        begin
            r = $urandom_range(0, 99);
            k = ($urandom_range(0, 4) == 0) ? fresh_key() : held_key();
            if (r < 30)
                queue_cmd(krt_pkg::CMD_INSERT,
                          ($urandom_range(0, 4) == 0) ? held_key() : fresh_key(),
                          rand_word(), rand_word());
            else if (r < 55)
                queue_cmd(krt_pkg::CMD_UPDATE, k, rand_word(), rand_word());
            else if (r < 80)
                queue_cmd(krt_pkg::CMD_DELETE, k, rand_word(), rand_word());
            else if (r < 88)
                queue_cmd(krt_pkg::CMD_DUMP, rand_word(), rand_word(), rand_word());
            else
                queue_cmd(krt_pkg::cmd_t'($urandom_range(0, 3)), rand_word(), rand_word(),
                          rand_word());
        end

        while (gen_keys.size() > 0)
        begin
            r = $urandom_range(0, 99);
            if (r < 85)
                queue_cmd(krt_pkg::CMD_DELETE, held_key(), rand_word(), rand_word());
            else if (r < 93)
                queue_cmd(krt_pkg::CMD_UPDATE, held_key(), rand_word(), rand_word());
            else
                queue_cmd(krt_pkg::CMD_DELETE, fresh_key(), rand_word(), rand_word());
        end
        queue_cmd(krt_pkg::CMD_DUMP, rand_word(), rand_word(), rand_word());
        queue_cmd(krt_pkg::CMD_DELETE, rand_word(), rand_word(), rand_word());

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() > 0 || s_tvalid)
            @(posedge clk);
        while (expected_beats.size() > 0)
            @(posedge clk);
        settle = 0;
        while (settle < 200)
        begin
            @(posedge clk);
            settle++;
        end

        $display("Ran %0d inserts, %0d updates, %0d deletes and %0d dumps; %0d beats checked.",
                 cmd_tally[krt_pkg::CMD_INSERT], cmd_tally[krt_pkg::CMD_UPDATE],
                 cmd_tally[krt_pkg::CMD_DELETE], cmd_tally[krt_pkg::CMD_DUMP], beats_seen);
        $display("Statuses seen: full %0d, duplicate %0d, not found %0d, empty %0d; peak %0d.",
                 status_tally[krt_pkg::ST_FULL], status_tally[krt_pkg::ST_DUP],
                 status_tally[krt_pkg::ST_MISSING], status_tally[krt_pkg::ST_EMPTY],
                 peak_count);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #10000000;
        $display("Timed out with %0d result beats still outstanding.", expected_beats.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* keyed_record_table.f */
rtl/krt_pkg.sv
rtl/krt_mem.sv
rtl/krt_ctrl.sv
rtl/keyed_record_table.sv
sim/tb_keyed_record_table.sv
